// ===== design/arrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrt_pkg
// Shared types and codes for the address range region table.
// ----------------------------------------------------------------------------
package arrt_pkg;

  // Table depth default
  localparam int MAX_REGIONS_DEF = 64;

  // Field widths
  localparam int ADDR_W = 64;
  localparam int ID_W   = 6;
  localparam int ST_W   = 3;
  localparam int KIND_W = 2;

  // Request kinds
  localparam logic [KIND_W-1:0] REQ_REGISTER = 2'd0;
  localparam logic [KIND_W-1:0] REQ_RESOLVE  = 2'd1;
  localparam logic [KIND_W-1:0] REQ_READ     = 2'd2;
  localparam logic [KIND_W-1:0] REQ_UNUSED   = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd2;
  localparam logic [ST_W-1:0] ST_OVERLAP  = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
  localparam logic [ST_W-1:0] ST_UNMAPPED = 3'd5;
  localparam logic [ST_W-1:0] ST_PARTIAL  = 3'd6;
  localparam logic [ST_W-1:0] ST_NOENTRY  = 3'd7;

  // Request transfer
  typedef struct packed {
    logic [KIND_W-1:0] req_type;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] span;
    logic [ID_W-1:0]   entry_id;
  } arrt_req_t;

  // Result transfer
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   region_id;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_size;
  } arrt_rsp_t;

  // Request token walking the cell chain
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] end_addr;
    logic [ID_W-1:0]   entry_id;
    logic              done;   // outcome already decided
    logic              hit;    // resolve: some region intersects
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
  } arrt_tok_t;

endpackage

// ===== design/arrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrt_cell
// One table slot: holds one region and checks the passing request token
// against it, then hands the token to the next slot.
// ----------------------------------------------------------------------------
module arrt_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CW-1:0]      count,
  input  logic               in_valid,
  input  arrt_pkg::arrt_tok_t in_tok,
  output logic               out_valid,
  output arrt_pkg::arrt_tok_t out_tok
);
  import arrt_pkg::*;

  localparam logic [CW-1:0]   CELL_IDX = CW'(IDX);
  localparam logic [ID_W-1:0] CELL_ID  = ID_W'(IDX % (2 ** ID_W));
  localparam bit              ID_REACH = (IDX < (2 ** ID_W));

  // Stored region
  logic [ADDR_W-1:0] r_base;
  logic [ADDR_W-1:0] r_size;
  logic [ADDR_W-1:0] r_end;

  logic      occupied;
  logic      at_free;
  logic      overlap;
  logic      contain;
  logic      wr_en;
  arrt_tok_t tok_next;

  assign occupied = (CELL_IDX < count);
  assign at_free  = (CELL_IDX == count);
  assign overlap  = occupied && (in_tok.address < r_end) && (r_base < in_tok.end_addr);
  assign contain  = occupied && (in_tok.address >= r_base) && (in_tok.end_addr <= r_end);

  // Per-slot check
  always_comb begin
    tok_next = in_tok;
    wr_en    = 1'b0;
    if (in_valid && !in_tok.done) begin
      case (in_tok.kind)
        REQ_REGISTER: begin
          if (overlap) begin
            tok_next.done   = 1'b1;
            tok_next.status = ST_OVERLAP;
            tok_next.id     = CELL_ID;
          end else if (at_free) begin
            wr_en           = 1'b1;
            tok_next.done   = 1'b1;
            tok_next.status = ST_OK;
            tok_next.id     = CELL_ID;
          end
        end
        REQ_RESOLVE: begin
          if (contain) begin
            tok_next.done   = 1'b1;
            tok_next.status = ST_OK;
            tok_next.id     = CELL_ID;
            tok_next.offset = in_tok.address - r_base;
          end else if (overlap) begin
            tok_next.hit = 1'b1;
            tok_next.id  = CELL_ID;
          end
        end
        REQ_READ: begin
          if (ID_REACH && occupied && (in_tok.entry_id == CELL_ID)) begin
            tok_next.done   = 1'b1;
            tok_next.status = ST_OK;
            tok_next.base   = r_base;
            tok_next.size   = r_size;
          end
        end
        default: begin
          tok_next = in_tok;
        end
      endcase
    end
  end

  // Region storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      r_base <= in_tok.address;
      r_size <= in_tok.span;
      r_end  <= in_tok.end_addr;
    end
  end

  // Token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_tok <= tok_next;
  end

endmodule

// ===== design/address_range_region_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_region_table
// Table of non-overlapping 64-bit regions with register, resolve and
// entry-read requests, built as a chain of region slots.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfer happens on a clock edge with start high and busy low.
//   request carries req_type, address, span and entry_id. Request
//   type 3 is dropped: no result and no state change.
//   Each accepted request of type 0, 1 or 2 yields one result: done is high
//   for exactly one cycle with result valid alongside. The receiver cannot
//   stall; the result must be taken in that cycle.
//   The request passes one entry stage that does the zero-length and
//   end-overflow checks, the slot registers as the request token walks
//   the chain, and one result register.
//   busy is high from the accepting edge until done rises, so a new request
//   can be taken in the done cycle; no new request is taken while one is
//   still in the slot chain.
//   Reset empties the table (region count zero); no clearing pass is needed.
// ----------------------------------------------------------------------------
module address_range_region_table #(
  parameter int MAX_REGIONS = arrt_pkg::MAX_REGIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  arrt_pkg::arrt_req_t request,
  output logic                done,
  output arrt_pkg::arrt_rsp_t result
);
  import arrt_pkg::*;

  localparam int CW = $clog2(MAX_REGIONS + 1);

  logic [CW-1:0] count;
  logic          accept;
  logic          e_valid;
  arrt_tok_t     e_tok;
  arrt_tok_t     e_tok_next;
  logic [ADDR_W:0] sum;

  logic      chain_valid [0:MAX_REGIONS];
  arrt_tok_t chain_tok   [0:MAX_REGIONS];

  logic      last_valid;
  arrt_tok_t last_tok;
  arrt_rsp_t rsp_next;
  logic      grow;

  assign accept = start && !busy && (request.req_type != REQ_UNUSED);
  assign sum    = {1'b0, request.address} + {1'b0, request.span};

  // Entry checks: zero length and end overflow
  always_comb begin
    e_tok_next            = '0;
    e_tok_next.kind       = request.req_type;
    e_tok_next.address    = request.address;
    e_tok_next.span       = request.span;
    e_tok_next.end_addr   = sum[ADDR_W-1:0];
    e_tok_next.entry_id   = request.entry_id;
    if (request.req_type != REQ_READ) begin
      if (request.span == '0) begin
        e_tok_next.done   = 1'b1;
        e_tok_next.status = ST_ZERO;
      end else if (sum[ADDR_W]) begin
        e_tok_next.done   = 1'b1;
        e_tok_next.status = ST_OVERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_tok <= e_tok_next;
    end
  end

  assign chain_valid[0] = e_valid;
  assign chain_tok[0]   = e_tok;

  // Slot chain
  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    arrt_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .count     (count),
      .in_valid  (chain_valid[g]),
      .in_tok    (chain_tok[g]),
      .out_valid (chain_valid[g+1]),
      .out_tok   (chain_tok[g+1])
    );
  end

  assign last_valid = chain_valid[MAX_REGIONS];
  assign last_tok   = chain_tok[MAX_REGIONS];

  // Result from the token, or the final outcome for requests no slot settled
  always_comb begin
    rsp_next             = '0;
    rsp_next.status      = last_tok.status;
    rsp_next.region_id   = last_tok.id;
    rsp_next.offset      = last_tok.offset;
    rsp_next.region_base = last_tok.base;
    rsp_next.region_size = last_tok.size;
    if (!last_tok.done) begin
      rsp_next = '0;
      case (last_tok.kind)
        REQ_REGISTER: rsp_next.status = ST_FULL;
        REQ_RESOLVE: begin
          if (last_tok.hit) begin
            rsp_next.status    = ST_PARTIAL;
            rsp_next.region_id = last_tok.id;
          end else begin
            rsp_next.status = ST_UNMAPPED;
          end
        end
        default: rsp_next.status = ST_NOENTRY;
      endcase
    end
  end

  assign grow = last_valid && last_tok.done && (last_tok.kind == REQ_REGISTER)
                && (last_tok.status == ST_OK);

  // Result register, count and busy
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      busy  <= 1'b0;
      count <= '0;
    end else begin
      done <= last_valid;
      if (accept) begin
        busy <= 1'b1;
      end else if (last_valid) begin
        busy <= 1'b0;
      end
      if (grow) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last_valid) begin
      result <= rsp_next;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the address range region table. A local mirror of
// the region table predicts every result at the transfer edge of its request.
// A monitor compares each done strobe field by field with the oldest
// prediction. Stimulus starts with a directed pass over the register, resolve
// and read checks. Random traffic shaped around the stored regions follows:
// sub-ranges, ranges straddling region edges, adjacent clusters and crafted
// overlaps. It fills the table and keeps going once the table is full.
// ----------------------------------------------------------------------------
module tb_top;
  import arrt_pkg::*;

  localparam int NREG    = MAX_REGIONS_DEF;
  localparam int LATENCY = NREG + 2;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  logic      done;
  arrt_req_t request;
  arrt_rsp_t result;

  // Mirror of the region table
  logic [ADDR_W-1:0] tbl_base [NREG];
  logic [ADDR_W-1:0] tbl_size [NREG];
  int unsigned       tbl_count = 0;

  arrt_rsp_t   due_results [$];
  int unsigned n_errors   = 0;
  int unsigned n_checked  = 0;
  int unsigned n_accepted = 0;
  int unsigned n_ignored  = 0;
  int unsigned status_seen [8];
  bit          gaps_on = 1'b1;

  address_range_region_table dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Table model: computes the result of one request and updates the mirror.
  // Returns 0 for the unused request type, which yields nothing.
  // --------------------------------------------------------------------------
  function automatic bit apply_request(input arrt_req_t rq, output arrt_rsp_t rsp);
    logic [ADDR_W:0]   sum;
    logic [ADDR_W-1:0] stop;
    logic [ADDR_W-1:0] rb;
    logic [ADDR_W-1:0] re;
    bit                hit;
    int unsigned       last;
    rsp  = '0;
    hit  = 1'b0;
    last = 0;
    if (rq.req_type == REQ_UNUSED) return 1'b0;
    if (rq.req_type == REQ_READ) begin
      if (rq.entry_id < tbl_count) begin
        rsp.status      = ST_OK;
        rsp.region_base = tbl_base[rq.entry_id];
        rsp.region_size = tbl_size[rq.entry_id];
      end else begin
        rsp.status = ST_NOENTRY;
      end
      return 1'b1;
    end
    // zero length and end overflow come first for both register and resolve
    if (rq.span == '0) begin
      rsp.status = ST_ZERO;
      return 1'b1;
    end
    sum = {1'b0, rq.address} + {1'b0, rq.span};
    if (sum[ADDR_W]) begin
      rsp.status = ST_OVERFLOW;
      return 1'b1;
    end
    stop = sum[ADDR_W-1:0];
    // walk the stored regions in id order
    for (int i = 0; i < tbl_count; i++) begin
      rb = tbl_base[i];
      re = rb + tbl_size[i];
      if (rq.req_type == REQ_RESOLVE && rq.address >= rb && stop <= re) begin
        rsp.status    = ST_OK;
        rsp.region_id = ID_W'(i);
        rsp.offset    = rq.address - rb;
        return 1'b1;
      end
      if (rq.address < re && rb < stop) begin
        if (rq.req_type == REQ_REGISTER) begin
          rsp.status    = ST_OVERLAP;
          rsp.region_id = ID_W'(i);
          return 1'b1;
        end
        hit  = 1'b1;
        last = i;
      end
    end
    if (rq.req_type == REQ_RESOLVE) begin
      rsp.status    = hit ? ST_PARTIAL : ST_UNMAPPED;
      rsp.region_id = hit ? ID_W'(last) : '0;
      return 1'b1;
    end
    if (tbl_count >= NREG) begin
      rsp.status = ST_FULL;
      return 1'b1;
    end
    tbl_base[tbl_count] = rq.address;
    tbl_size[tbl_count] = rq.span;
    rsp.status    = ST_OK;
    rsp.region_id = ID_W'(tbl_count);
    tbl_count++;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] got,
                             input logic [ADDR_W-1:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: checks the done strobe, then records a new request
  // transfer. Both happen at the same edge when a request is taken in the
  // done cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    arrt_rsp_t want;
    arrt_rsp_t fresh;
    if (!rst) begin
      if (done !== 1'b0 && done !== 1'b1) begin
        report_mismatch("done strobe (unknown)", ADDR_W'(done), '0);
      end else if (done) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with none due, status", ADDR_W'(result.status), '0);
        end else begin
          want = due_results.pop_front();
          check_field("status", ADDR_W'(result.status), ADDR_W'(want.status));
          check_field("region_id", ADDR_W'(result.region_id), ADDR_W'(want.region_id));
          check_field("offset", result.offset, want.offset);
          check_field("region_base", result.region_base, want.region_base);
          check_field("region_size", result.region_size, want.region_size);
          status_seen[want.status]++;
          n_checked++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (apply_request(request, fresh)) begin
          due_results.insert(due_results.size(), fresh);
          n_accepted++;
        end else begin
          n_ignored++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic arrt_req_t make_req(input logic [KIND_W-1:0] kind,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [ADDR_W-1:0] count,
                                         input logic [ID_W-1:0] id);
    arrt_req_t rq;
    rq.req_type = kind;
    rq.address  = addr;
    rq.span     = count;
    rq.entry_id = id;
    return rq;
  endfunction

  // One request transfer; start stays high so back-to-back requests need no gap
  task automatic send_request(input arrt_req_t rq);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 99) < 9) begin
      start = 1'b0;
      gap   = $urandom_range(1, LATENCY + 14);
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    request = rq;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Random request shaped against the regions stored so far
  function automatic arrt_req_t random_request(input int unsigned reg_pct);
    arrt_req_t         rq;
    int unsigned       roll;
    int unsigned       shape;
    int unsigned       idx;
    int unsigned       lead;
    bit                have;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] off;
    rq    = make_req(REQ_READ, rand_word(), rand_word(), ID_W'($urandom_range(0, 63)));
    roll  = $urandom_range(0, 99);
    shape = $urandom_range(0, 99);
    have  = tbl_count > 0;
    idx   = have ? $urandom_range(0, tbl_count - 1) : 0;
    b     = have ? tbl_base[idx] : '0;
    s     = have ? tbl_size[idx] : 64'd1;
    off   = rand_word() % s;
    if (roll < 5) begin
      // ignored request type, random content
      rq.req_type = REQ_UNUSED;
    end else if (roll < 5 + reg_pct) begin
      rq.req_type = REQ_REGISTER;
      if (shape < 10) begin
        rq.span = '0;
      end else if (shape < 20) begin
        rq.address = rand_word() | (64'd1 << 63);
        rq.span    = ~rq.address + 64'd1 + $urandom_range(0, 15);
      end else if (shape < 40 && have) begin
        // start inside a stored region
        rq.address = b + off;
        rq.span    = 64'd1 + (rand_word() >> $urandom_range(1, 63));
      end else begin
        rq.span = 64'd1 + (rand_word() >> $urandom_range(16, 63));
        if (have && shape < 55)
          rq.address = b - rq.span;          // ends where a region begins
        else if (have && shape < 70)
          rq.address = b + s;                // begins where a region ends
      end
    end else if (roll < 50 + reg_pct) begin
      rq.req_type = REQ_RESOLVE;
      if (shape < 5) begin
        rq.span = '0;
      end else if (shape < 10) begin
        rq.address = rand_word() | (64'd1 << 63);
        rq.span    = ~rq.address + 64'd1 + $urandom_range(0, 15);
      end else if (shape < 55 && have) begin
        // sub-range of one region
        rq.address = b + off;
        rq.span    = 64'd1 + rand_word() % (s - off);
      end else if (shape < 70 && have) begin
        // runs past the end of a region
        rq.address = b + off;
        rq.span    = (s - off) + 64'd1 + $urandom_range(0, 4095);
      end else if (shape < 80 && have) begin
        // starts before a region and runs into it
        lead       = $urandom_range(1, 4096);
        rq.address = b - lead;
        rq.span    = lead + 64'd1 + off;
      end else if (shape < 88 && have) begin
        // wide span over a region and its neighbors
        lead       = $urandom_range(0, 4096);
        rq.address = b - lead;
        rq.span    = s + lead + (rand_word() >> $urandom_range(8, 63)) + 64'd1;
      end else begin
        rq.span = 64'd1 + (rand_word() >> $urandom_range(0, 63));
      end
    end else begin
      if (have && shape < 75) rq.entry_id = ID_W'(idx);
    end
    return rq;
  endfunction

  // Random traffic until the given number of answered requests is sent
  task automatic run_random(input int unsigned items, input int unsigned reg_pct);
    arrt_req_t   rq;
    int unsigned sent;
    sent = 0;
    while (sent < items) begin
      rq = random_request(reg_pct);
      send_request(rq);
      if (rq.req_type != REQ_UNUSED) sent++;
    end
  endtask

  // Stop driving and wait for every outstanding result, then the pipe depth
  task automatic drain_results();
    int unsigned waited;
    start  = 1'b0;
    waited = 0;
    while (due_results.size() != 0 && waited < 8 * LATENCY) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Register checks in priority order, a region at the bottom of the space and one at the top that overflows
  task automatic test_register_checks();
    send_request(make_req(REQ_REGISTER, 64'h1000, 64'd0, '0));
    send_request(make_req(REQ_REGISTER, ADDR_MAX, 64'd1, '0));
    send_request(make_req(REQ_REGISTER, 64'd1, ADDR_MAX, '0));
    send_request(make_req(REQ_REGISTER, 64'd0, 64'h1000, '0));
    send_request(make_req(REQ_REGISTER, ADDR_MAX - 64'hff, 64'h100, '0));
    send_request(make_req(REQ_REGISTER, 64'h1000, 64'h1000, '0));
    // overlaps regions 0 and 1: lowest id reported
    send_request(make_req(REQ_REGISTER, 64'h800, 64'h1000, '0));
    send_request(make_req(REQ_REGISTER, 64'h1fff, 64'd1, '0));
  endtask

  // Resolve: hits, whole region, partial over two regions, past an end, unmapped
  task automatic test_resolve_checks();
    send_request(make_req(REQ_RESOLVE, 64'h10, 64'd0, '0));
    send_request(make_req(REQ_RESOLVE, ADDR_MAX, 64'd1, '0));
    send_request(make_req(REQ_RESOLVE, 64'h1800, 64'h100, '0));
    send_request(make_req(REQ_RESOLVE, 64'd0, 64'h1000, '0));
    send_request(make_req(REQ_RESOLVE, 64'hf00, 64'h200, '0));
    send_request(make_req(REQ_RESOLVE, 64'h1f00, 64'h200, '0));
    send_request(make_req(REQ_RESOLVE, 64'h5000, 64'h10, '0));
    send_request(make_req(REQ_RESOLVE, ADDR_MAX - 64'd1, 64'd1, '0));
  endtask

  // Entry reads in and beyond the table; the unused type must not append
  task automatic test_entry_reads();
    send_request(make_req(REQ_READ, '0, '0, 6'd0));
    send_request(make_req(REQ_READ, ADDR_MAX, ADDR_MAX, 6'd1));
    send_request(make_req(REQ_READ, '0, '0, 6'd3));
    send_request(make_req(REQ_READ, '0, '0, 6'd63));
    send_request(make_req(REQ_UNUSED, 64'h9000, 64'h10, 6'd2));
    send_request(make_req(REQ_READ, '0, '0, 6'd3));
    send_request(make_req(REQ_READ, '0, '0, 6'd2));
  endtask

  // Random traffic with no gaps between requests
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    run_random(150, 15);
    gaps_on = 1'b1;
  endtask

  // Random traffic with random gaps on a partly filled table
  task automatic test_random_traffic();
    run_random(400, 15);
  endtask

  // Register until every slot is taken
  task automatic test_fill_table();
    arrt_req_t   rq;
    int unsigned tries;
    tries = 0;
    while (tbl_count < NREG && tries < 2000) begin
      rq = random_request(100);
      send_request(rq);
      tries++;
    end
  endtask

  // Full table: appends refused, stored slots read and resolved at random
  task automatic test_full_table();
    run_random(350, 25);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    for (int k = 0; k < 8; k++) status_seen[k] = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_register_checks();
    test_resolve_checks();
    test_entry_reads();
    test_back_to_back();
    test_random_traffic();
    test_fill_table();
    test_full_table();
    drain_results();

    if (due_results.size() != 0)
      report_mismatch("results still due at end, count", ADDR_W'(due_results.size()), '0);
    $display("Covered %0d requests (%0d ignored type), %0d results checked, %0d regions stored",
             n_accepted, n_ignored, n_checked, tbl_count);
    $display("Status mix: ok %0d zero %0d ovf %0d overlap %0d full %0d unmapped %0d %s %0d, %s %0d",
             status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_OVERFLOW],
             status_seen[ST_OVERLAP], status_seen[ST_FULL], status_seen[ST_UNMAPPED],
             "partial", status_seen[ST_PARTIAL], "no entry", status_seen[ST_NOENTRY]);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("run timed out");
    $display("FAIL");
    $finish;
  end

endmodule
